FILE: rtl/assert_macros.svh
// assert_macros.svh: assertion macros shared by the divider RTL.
// Relies on each asserting module having clk and rst in scope.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef SYNTHESIS

// Clocked property, ignored while rst is high.
`define ASSERT_CLK(lbl, prop) \
  lbl: assert property (@(posedge clk) disable iff (rst) (prop)) \
    else $error("assertion failed");

// Condition that must never hold outside reset.
`define ASSERT_NEVER(lbl, expr) \
  lbl: assert property (@(posedge clk) disable iff (rst) !(expr)) \
    else $error("forbidden condition seen");

`else

`define ASSERT_CLK(lbl, prop)
`define ASSERT_NEVER(lbl, expr)

`endif

`endif

FILE: rtl/idu_pkg.sv
// idu_pkg: command codes and the per-word control bundle of the divider.
// No dependencies; used by idu_cell and integer_divide_unit_64_core.
package idu_pkg;

  localparam int unsigned CMD_WIDTH = 2;
  localparam int unsigned FIELD_WIDTH = 64;

  localparam logic [CMD_WIDTH-1:0] CMD_UDIV = 2'd0;
  localparam logic [CMD_WIDTH-1:0] CMD_UREM = 2'd1;
  localparam logic [CMD_WIDTH-1:0] CMD_SDIV = 2'd2;

  // Control that rides along with a word through the cell row.
  typedef struct packed {
    logic rem;  // deliver remainder
    logic neg;  // negate quotient at the end
    logic dz;   // divisor was zero
  } ctl_t;

endpackage

FILE: rtl/integer_divide_unit_64_core.sv
// integer_divide_unit_64_core: pipelined restoring divider, top level.
// Depends on idu_pkg, idu_cell and assert_macros.svh.
//
// Usage:
//   Request channel (req_valid/req_ready) carries cmd, dividend, divisor.
//   cmd: unsigned quotient, unsigned remainder, signed quotient (code three
//   also runs as signed quotient). Operands are the low DATA_WIDTH bits.
//   Response channel (rsp_valid/rsp_ready) carries result and div_by_zero;
//   result bits above DATA_WIDTH read as zero.
// Structure: an operand register (sign handling, zero check), then a row of
//   DATA_WIDTH identical cells, each doing one quotient bit per cycle of row
//   advance and handing its partial remainder on, then the result register
//   (sign fix). Throughput: one word per cycle while the row advances;
//   up to DATA_WIDTH + 2 words in flight.
// Stall: the whole row advances together. While a response waits
//   (rsp_valid high, rsp_ready low) the row freezes and req_ready drops;
//   it rises again the cycle the waiting response is taken.
// Zero divisor: quotient 0, remainder = dividend, div_by_zero set.
// Reset: rst (synchronous) clears all valid bits; no words survive it.
`include "assert_macros.svh"

module integer_divide_unit_64_core #(
  parameter int unsigned DATA_WIDTH = 64
) (
  input  logic                                clk,
  input  logic                                rst,
  input  logic                                req_valid,
  output logic                                req_ready,
  input  logic [idu_pkg::CMD_WIDTH-1:0]       cmd,
  input  logic [idu_pkg::FIELD_WIDTH-1:0]     dividend,
  input  logic [idu_pkg::FIELD_WIDTH-1:0]     divisor,
  output logic                                rsp_valid,
  input  logic                                rsp_ready,
  output logic [idu_pkg::FIELD_WIDTH-1:0]     result,
  output logic                                div_by_zero
);

  localparam int unsigned W = DATA_WIDTH;

  // row advance: output register is free or being drained
  logic en;

  // stage 0 is the operand register, stage W the last cell
  logic          sv   [0:W];
  logic [W-1:0]  sr   [0:W];
  logic [W-1:0]  snq  [0:W];
  logic [W-1:0]  sd   [0:W];
  idu_pkg::ctl_t sctl [0:W];

  // operand prep
  logic [W-1:0]  n_in;
  logic [W-1:0]  d_in;
  logic          is_signed;
  logic          n_neg;
  logic          d_neg;
  idu_pkg::ctl_t ctl_in;

  // result fix
  logic [W-1:0]  q_last;
  logic [W-1:0]  res_w;

  assign en        = ~rsp_valid | rsp_ready;
  assign req_ready = en;

  always_comb begin
    n_in       = dividend[W-1:0];
    d_in       = divisor[W-1:0];
    is_signed  = cmd[1];
    n_neg      = is_signed & n_in[W-1];
    d_neg      = is_signed & d_in[W-1];
    ctl_in.rem = (cmd == idu_pkg::CMD_UREM);
    ctl_in.neg = n_neg ^ d_neg;
    ctl_in.dz  = (d_in == '0);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      sv[0] <= 1'b0;
    end else if (en) begin
      sv[0] <= req_valid;
    end
  end

  // magnitudes; the most negative value maps to itself, which is its
  // correct unsigned magnitude
  always_ff @(posedge clk) begin
    if (en) begin
      sr[0]   <= '0;
      snq[0]  <= (n_in ^ {W{n_neg}}) + W'(n_neg);
      sd[0]   <= (d_in ^ {W{d_neg}}) + W'(d_neg);
      sctl[0] <= ctl_in;
    end
  end

  for (genvar g = 0; g < W; g++) begin : g_cell
    idu_cell #(
      .DATA_WIDTH(W)
    ) u_cell (
      .clk       (clk),
      .rst       (rst),
      .en        (en),
      .prev_valid(sv[g]),
      .prev_r    (sr[g]),
      .prev_nq   (snq[g]),
      .prev_d    (sd[g]),
      .prev_ctl  (sctl[g]),
      .valid     (sv[g+1]),
      .r         (sr[g+1]),
      .nq        (snq[g+1]),
      .d         (sd[g+1]),
      .ctl       (sctl[g+1])
    );
  end

  // With a zero divisor the row leaves the dividend in the remainder,
  // so only the quotient needs forcing.
  always_comb begin
    q_last = snq[W];
    if (sctl[W].rem) begin
      res_w = sr[W];
    end else if (sctl[W].dz) begin
      res_w = '0;
    end else if (sctl[W].neg) begin
      res_w = (~q_last) + W'(1);
    end else begin
      res_w = q_last;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      rsp_valid <= 1'b0;
    end else if (en) begin
      rsp_valid <= sv[W];
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      result      <= idu_pkg::FIELD_WIDTH'(res_w);
      div_by_zero <= sctl[W].dz;
    end
  end

  `ASSERT_CLK(a_accept_loads_stage0, (req_valid && req_ready) |=> sv[0])
  `ASSERT_CLK(a_dz_quotient_zero, (en && sv[W] && sctl[W].dz && !sctl[W].rem) |=> (result == '0))
  `ASSERT_CLK(a_rsp_from_last_cell, (en && !sv[W]) |=> !rsp_valid)

endmodule

FILE: rtl/idu_cell.sv
// idu_cell: one restoring-division step with its stage register.
// Depends on idu_pkg and assert_macros.svh.
`include "assert_macros.svh"

module idu_cell #(
  parameter int unsigned DATA_WIDTH = 64
) (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  en,
  input  logic                  prev_valid,
  input  logic [DATA_WIDTH-1:0] prev_r,
  input  logic [DATA_WIDTH-1:0] prev_nq,
  input  logic [DATA_WIDTH-1:0] prev_d,
  input  idu_pkg::ctl_t         prev_ctl,
  output logic                  valid,
  output logic [DATA_WIDTH-1:0] r,
  output logic [DATA_WIDTH-1:0] nq,
  output logic [DATA_WIDTH-1:0] d,
  output idu_pkg::ctl_t         ctl
);

  localparam int unsigned W = DATA_WIDTH;

  logic [W:0]   part;
  logic [W:0]   diff;
  logic         take;
  logic [W-1:0] r_next;
  logic [W-1:0] nq_next;

  // Shift next dividend bit into the partial remainder; top bit is the carry.
  always_comb begin
    part    = {prev_r, prev_nq[W-1]};
    diff    = part - {1'b0, prev_d};
    take    = ~diff[W];
    r_next  = take ? diff[W-1:0] : part[W-1:0];
    // dividend bits leave at the top, quotient bits enter at the bottom
    nq_next = {prev_nq[W-2:0], take};
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      valid <= 1'b0;
    end else if (en) begin
      valid <= prev_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      r   <= r_next;
      nq  <= nq_next;
      d   <= prev_d;
      ctl <= prev_ctl;
    end
  end

  `ASSERT_CLK(a_rem_below_div, (valid && !ctl.dz) |-> (r < d))
  `ASSERT_NEVER(a_zero_div_takes, valid && ctl.dz && !nq[0])
  `ASSERT_CLK(a_freeze_on_stall, !en |=> ($stable(valid) && $stable(r) && $stable(nq)))

endmodule

FILE: test/tb_integer_divide_unit_64_core.sv
// tb_integer_divide_unit_64_core: self-checking bench for the pipelined 64-bit divider.
// Depends on idu_pkg and integer_divide_unit_64_core; needs no files or arguments.
module tb_integer_divide_unit_64_core;
  timeunit 1ns;
  timeprecision 1ps;

  // Code three is not documented as its own op; bit 1 selects signed divide.
  localparam logic [idu_pkg::CMD_WIDTH-1:0] CMD_SDIV_ALT = 2'd3;

  localparam int unsigned DATA_WIDTH = 64;
  // Accepted word to rsp_valid: the cell row plus the result register.
  localparam int unsigned LATENCY    = DATA_WIDTH + 1;
  // Cycles with no word moving on either channel before the run is abandoned.
  // The longest legal quiet spell is the long response hold (plus pipe depth).
  localparam int unsigned IDLE_LIMIT = 5000;
  localparam int unsigned LONG_HOLD  = 400;

  localparam logic [63:0] SIGN_MIN = 64'h8000_0000_0000_0000;
  localparam logic [63:0] SIGN_MAX = 64'h7fff_ffff_ffff_ffff;
  localparam logic [63:0] ALL_ONES = 64'hffff_ffff_ffff_ffff;

  // Expected response word.
  typedef struct packed {
    logic [63:0] value;
    logic        dz;
  } division_word_t;

  logic                            clk = 1'b0;
  logic                            rst = 1'b1;
  logic                            req_valid = 1'b0;
  logic                            req_ready;
  logic [idu_pkg::CMD_WIDTH-1:0]   cmd = idu_pkg::CMD_UDIV;
  logic [idu_pkg::FIELD_WIDTH-1:0] dividend = '0;
  logic [idu_pkg::FIELD_WIDTH-1:0] divisor = '0;
  logic                            rsp_valid;
  logic                            rsp_ready = 1'b0;
  logic [idu_pkg::FIELD_WIDTH-1:0] result;
  logic                            div_by_zero;

  division_word_t results_due[$];
  division_word_t oldest_due;
  int             fail_count    = 0;
  int             words_sent    = 0;
  int             words_checked = 0;
  int             quiet_cycles  = 0;

  // Knobs shared between the test tasks and the two driver processes.
  bit no_idle        = 1'b0;  // both sides run without gaps
  bit hold_off_start = 1'b0;  // receiver: begin one long stall

  integer_divide_unit_64_core #(
    .DATA_WIDTH(DATA_WIDTH)
  ) uut (
    .clk        (clk),
    .rst        (rst),
    .req_valid  (req_valid),
    .req_ready  (req_ready),
    .cmd        (cmd),
    .dividend   (dividend),
    .divisor    (divisor),
    .rsp_valid  (rsp_valid),
    .rsp_ready  (rsp_ready),
    .result     (result),
    .div_by_zero(div_by_zero)
  );

  initial begin
    forever #4 clk = ~clk;
  end

  // Predictor. Unsigned ops divide the raw patterns; signed divides the
  // magnitudes and flips the quotient when the signs differ, so the most
  // negative value over minus one comes back as itself. Zero divisor: the
  // quotient is zero, the remainder is the dividend, and the flag is set.
  function automatic division_word_t expected_division(logic [idu_pkg::CMD_WIDTH-1:0] op,
                                                       logic [63:0] n, logic [63:0] d);
    division_word_t o;
    logic [63:0]    n_mag;
    logic [63:0]    d_mag;
    logic [63:0]    q;
    o.dz = (d == '0);
    if (d == '0) begin
      o.value = (op == idu_pkg::CMD_UREM) ? n : '0;
    end else if (op == idu_pkg::CMD_SDIV || op == CMD_SDIV_ALT) begin
      n_mag   = n[63] ? -n : n;
      d_mag   = d[63] ? -d : d;
      q       = n_mag / d_mag;
      o.value = (n[63] ^ d[63]) ? -q : q;
    end else if (op == idu_pkg::CMD_UREM) begin
      o.value = n % d;
    end else begin
      o.value = n / d;
    end
    return o;
  endfunction

  // Operand mix: zero, small, powers of two and one less than each, the signed
  // extremes, small negatives, and full-width or shifted-down random patterns.
  function automatic logic [63:0] rand_operand();
    logic [63:0] v;
    int          k;
    v = {$urandom, $urandom};
    k = $urandom_range(0, 63);
    case ($urandom_range(0, 11))
      0:       return '0;
      1:       return 64'($urandom_range(1, 15));
      2:       return 64'(1) << k;
      3:       return (64'(1) << k) - 64'd1;
      4:       return SIGN_MIN;
      5:       return ALL_ONES;
      6:       return -64'($urandom_range(1, 15));
      7, 8:    return v >> k;
      default: return v;
    endcase
  endfunction

  // Scoreboard and watchdog. Everything is sampled at the rising edge, before
  // the edge's nonblocking updates land, so the order of processes is moot.
  always @(posedge clk) begin
    if (!rst) begin
      if (rsp_valid && rsp_ready) begin
        words_checked++;
        if (results_due.size() == 0) begin
          $error("response word with nothing outstanding: result %h div_by_zero %b",
                 result, div_by_zero);
          fail_count++;
        end else begin
          oldest_due = results_due.pop_front();
          if (result !== oldest_due.value) begin
            $error("result: expected %h, got %h", oldest_due.value, result);
            fail_count++;
          end
          if (div_by_zero !== oldest_due.dz) begin
            $error("div_by_zero: expected %b, got %b", oldest_due.dz, div_by_zero);
            fail_count++;
          end
        end
      end
      if (req_valid && req_ready) begin
        words_sent++;
        results_due.push_back(expected_division(cmd, dividend, divisor));
      end

      if ((req_valid && req_ready) || (rsp_valid && rsp_ready)) begin
        quiet_cycles <= 0;
      end else if (quiet_cycles >= IDLE_LIMIT) begin
        $display("timeout: %0d cycles with no word moving, %0d outstanding",
                 quiet_cycles, results_due.size());
        $display("FAILED: results differ");
        $finish;
      end else begin
        quiet_cycles <= quiet_cycles + 1;
      end
    end
  end

  // Response side. Mostly ready with short drops, an occasional medium
  // stall, and one long hold on request from the stall test. The hold is
  // counted here so the sender keeps pushing until the pipe backs up.
  initial begin
    int pick;
    int hold;
    forever begin
      @(posedge clk);
      if (hold_off_start) begin
        hold_off_start = 1'b0;
        rsp_ready <= 1'b0;
        repeat (LONG_HOLD) @(posedge clk);
      end else if (no_idle) begin
        rsp_ready <= 1'b1;
      end else begin
        pick = $urandom_range(0, 99);
        if (pick < 2) begin
          hold = $urandom_range(20, 60);
          rsp_ready <= 1'b0;
          repeat (hold) @(posedge clk);
        end else begin
          rsp_ready <= (pick >= 25);
        end
      end
    end
  end

  // Offer one word and return on the edge that takes it. Called on a rising
  // edge; valid is only lowered when a gap is actually inserted.
  task automatic send_word(logic [idu_pkg::CMD_WIDTH-1:0] op, logic [63:0] n,
                           logic [63:0] d);
    int pick;
    int gap;
    pick = $urandom_range(0, 99);
    if (no_idle || pick < 60) gap = 0;
    else if (pick < 92) gap = $urandom_range(1, 3);
    else gap = $urandom_range(10, 40);
    if (gap > 0) begin
      req_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    req_valid <= 1'b1;
    cmd       <= op;
    dividend  <= n;
    divisor   <= d;
    do @(posedge clk); while (!req_ready);
  endtask

  // Sender pause: hold off until every outstanding word has come back.
  task automatic wait_for_drain();
    req_valid <= 1'b0;
    while (results_due.size() != 0) @(posedge clk);
  endtask

  // Corners: full-scale operands, top-bit divisors, all four codes, zero
  // divisor for each op, and the signed overflow case.
  task automatic check_directed_corners();
    send_word(idu_pkg::CMD_UDIV, ALL_ONES, 64'd1);
    send_word(idu_pkg::CMD_UDIV, ALL_ONES, ALL_ONES);
    send_word(idu_pkg::CMD_UDIV, 64'd0, ALL_ONES);
    send_word(idu_pkg::CMD_UDIV, 64'd5, 64'd0);
    send_word(idu_pkg::CMD_UDIV, ALL_ONES, SIGN_MIN);
    send_word(idu_pkg::CMD_UDIV, 64'd123456789, 64'd10);
    send_word(idu_pkg::CMD_UREM, ALL_ONES, 64'd0);
    send_word(idu_pkg::CMD_UREM, ALL_ONES, SIGN_MIN);
    send_word(idu_pkg::CMD_UREM, 64'd0, 64'd7);
    send_word(idu_pkg::CMD_UREM, ALL_ONES, 64'd10);
    send_word(idu_pkg::CMD_SDIV, SIGN_MIN, ALL_ONES);
    send_word(idu_pkg::CMD_SDIV, SIGN_MIN, 64'd1);
    send_word(idu_pkg::CMD_SDIV, -64'd7, 64'd2);
    send_word(idu_pkg::CMD_SDIV, 64'd7, -64'd2);
    send_word(idu_pkg::CMD_SDIV, -64'd7, -64'd2);
    send_word(idu_pkg::CMD_SDIV, ALL_ONES, 64'd0);
    send_word(idu_pkg::CMD_SDIV, SIGN_MAX, ALL_ONES);
    send_word(idu_pkg::CMD_SDIV, 64'd0, ALL_ONES);
    send_word(CMD_SDIV_ALT, SIGN_MIN, ALL_ONES);
    send_word(CMD_SDIV_ALT, -64'd100, 64'd7);
    send_word(CMD_SDIV_ALT, 64'd100, 64'd0);
    wait_for_drain();
  endtask

  task automatic check_random_operands(int count);
    repeat (count) begin
      send_word(idu_pkg::CMD_WIDTH'($urandom_range(0, 3)), rand_operand(), rand_operand());
    end
    wait_for_drain();
  endtask

  // Full rate both ways: one word in and one out every cycle.
  task automatic check_back_to_back(int count);
    no_idle = 1'b1;
    repeat (count) begin
      send_word(idu_pkg::CMD_WIDTH'($urandom_range(0, 3)), rand_operand(), rand_operand());
    end
    wait_for_drain();
    no_idle = 1'b0;
  endtask

  // Receiver stalls for a long stretch while the sender keeps offering words
  // with its usual random gaps: the row fills, req_ready drops, then everything unwinds.
  task automatic check_response_stall(int count);
    hold_off_start = 1'b1;
    repeat (count) begin
      send_word(idu_pkg::CMD_WIDTH'($urandom_range(0, 3)), rand_operand(), rand_operand());
    end
    wait_for_drain();
  endtask

  initial begin
    repeat (3) @(posedge clk);
    rst <= 1'b0;

    check_directed_corners();
    check_random_operands(1000);
    check_back_to_back(300);
    check_response_stall(200);
    check_random_operands(380);

    // Tail: let any stray word surface before the verdict.
    wait_for_drain();
    repeat (LATENCY + 8) @(posedge clk);
    if (results_due.size() != 0) begin
      $error("%0d expected words never came back", results_due.size());
      fail_count++;
    end

    $display("Covered %0d words in, %0d out: corner operands, all four codes, random mixes,",
             words_sent, words_checked);
    $display("full-rate bursts and a %0d-cycle response stall that backed up the pipe.",
             LONG_HOLD);
    if (fail_count == 0) begin
      $display("PASSED: all results match");
    end else begin
      $display("FAILED: results differ");
    end
    $finish;
  end

endmodule

FILE: filelist.f
+incdir+rtl
rtl/idu_pkg.sv
rtl/idu_cell.sv
rtl/integer_divide_unit_64_core.sv
test/tb_integer_divide_unit_64_core.sv
